FILE: hw/rtl/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared widths, register indexes, reset values and types of the Julia-set
// escape-time pixel engine.
// ----------------------------------------------------------------------------
package jesc_pkg;

   // field widths
   localparam int VALUE_W     = 32;
   localparam int STEP_W      = 31;
   localparam int SCALES_W    = 12;
   localparam int SCALE_W     = 4;
   localparam int COORD_W     = 10;
   localparam int COUNT_W     = 9;
   localparam int LEVEL_W     = 12;
   localparam int PROD_W      = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // parameter defaults
   localparam int DEF_MAX_ITERATIONS = 255;
   localparam int DEF_FRAC_BITS      = 26;
   localparam int DEF_COORD_BITS     = 10;

   // register reset values
   localparam logic signed [VALUE_W-1:0] RST_REAL_ORIGIN  = 32'shF8CCCCCD;
   localparam logic signed [VALUE_W-1:0] RST_IMAG_ORIGIN  = 32'shF8CCCCCD;
   localparam logic        [STEP_W-1:0]  RST_REAL_STEP    = 31'd314572;
   localparam logic        [STEP_W-1:0]  RST_IMAG_STEP    = 31'd314572;
   localparam logic signed [VALUE_W-1:0] RST_SEED_REAL    = 32'sd0;
   localparam logic signed [VALUE_W-1:0] RST_SEED_IMAG    = 32'sd0;
   localparam logic        [SCALES_W-1:0] RST_COLOR_SCALES = 12'hF59;

   // saturation bounds of the signed 32-bit range, held at product width
   localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh000000007FFFFFFF;
   localparam logic signed [PROD_W-1:0] SAT_LO = 64'shFFFFFFFF80000000;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REAL_ORIGIN  = 3'd0,
      CSR_IMAG_ORIGIN  = 3'd1,
      CSR_REAL_STEP    = 3'd2,
      CSR_IMAG_STEP    = 3'd3,
      CSR_SEED_REAL    = 3'd4,
      CSR_SEED_IMAG    = 3'd5,
      CSR_COLOR_SCALES = 3'd6
   } csr_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic signed [VALUE_W-1:0]  real_origin;
      logic signed [VALUE_W-1:0]  imag_origin;
      logic        [STEP_W-1:0]   real_step;
      logic        [STEP_W-1:0]   imag_step;
      logic signed [VALUE_W-1:0]  seed_real;
      logic signed [VALUE_W-1:0]  seed_imag;
      logic        [SCALES_W-1:0] color_scales;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic map_add;
      logic iter_mul;
      logic iter_upd;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic finished;
   } dp_status_type;

   // clamp a wide signed value into the signed 32-bit range
   function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[VALUE_W-1:0]);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/jesc_req_if.sv
// ----------------------------------------------------------------------------
// jesc_req_if
// Pixel request channel: valid/ready handshake carrying column and row.
// ----------------------------------------------------------------------------
interface jesc_req_if;
   logic                           valid;
   logic                           ready;
   logic [jesc_pkg::COORD_W-1:0]   column;
   logic [jesc_pkg::COORD_W-1:0]   row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);
endinterface

FILE: hw/rtl/jesc_rsp_if.sv
// ----------------------------------------------------------------------------
// jesc_rsp_if
// Result channel: valid/ready handshake carrying count and colour levels.
// ----------------------------------------------------------------------------
interface jesc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [jesc_pkg::COUNT_W-1:0]   escape_count;
   logic [jesc_pkg::LEVEL_W-1:0]   red_level;
   logic [jesc_pkg::LEVEL_W-1:0]   green_level;
   logic [jesc_pkg::LEVEL_W-1:0]   blue_level;

   modport source (output valid, output escape_count, output red_level,
                   output green_level, output blue_level, input ready);
   modport sink   (input valid, input escape_count, input red_level,
                   input green_level, input blue_level, output ready);
endinterface

FILE: hw/rtl/jesc_csr.sv
// ----------------------------------------------------------------------------
// jesc_csr
// Configuration register file: write-only, one register per index 0 to 6.
// ----------------------------------------------------------------------------
module jesc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jesc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jesc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output jesc_pkg::cfg_type                 cfg
);
   import jesc_pkg::*;

   cfg_type cfg_ff;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin  <= RST_REAL_ORIGIN;
         cfg_ff.imag_origin  <= RST_IMAG_ORIGIN;
         cfg_ff.real_step    <= RST_REAL_STEP;
         cfg_ff.imag_step    <= RST_IMAG_STEP;
         cfg_ff.seed_real    <= RST_SEED_REAL;
         cfg_ff.seed_imag    <= RST_SEED_IMAG;
         cfg_ff.color_scales <= RST_COLOR_SCALES;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REAL_ORIGIN:  cfg_ff.real_origin  <= $signed(csr_wdata[VALUE_W-1:0]);
            CSR_IMAG_ORIGIN:  cfg_ff.imag_origin  <= $signed(csr_wdata[VALUE_W-1:0]);
            CSR_REAL_STEP:    cfg_ff.real_step    <= csr_wdata[STEP_W-1:0];
            CSR_IMAG_STEP:    cfg_ff.imag_step    <= csr_wdata[STEP_W-1:0];
            CSR_SEED_REAL:    cfg_ff.seed_real    <= $signed(csr_wdata[VALUE_W-1:0]);
            CSR_SEED_IMAG:    cfg_ff.seed_imag    <= $signed(csr_wdata[VALUE_W-1:0]);
            CSR_COLOR_SCALES: cfg_ff.color_scales <= csr_wdata[SCALES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/jesc_datapath.sv
// ----------------------------------------------------------------------------
// jesc_datapath
// Start point mapping, complex square-and-add iteration, escape test, exit
// counter and colour level registers.
// ----------------------------------------------------------------------------
module jesc_datapath #(
   parameter int MAX_ITERATIONS = jesc_pkg::DEF_MAX_ITERATIONS,
   parameter int FRAC_BITS      = jesc_pkg::DEF_FRAC_BITS,
   parameter int COORD_BITS     = jesc_pkg::DEF_COORD_BITS
) (
   input  logic                            clock,
   input  jesc_pkg::cfg_type               cfg,
   input  jesc_pkg::dp_cmd_type            cmd,
   output jesc_pkg::dp_status_type         status,
   input  logic [jesc_pkg::COORD_W-1:0]    column,
   input  logic [jesc_pkg::COORD_W-1:0]    row,
   output logic [jesc_pkg::COUNT_W-1:0]    escape_count,
   output logic [jesc_pkg::LEVEL_W-1:0]    red_level,
   output logic [jesc_pkg::LEVEL_W-1:0]    green_level,
   output logic [jesc_pkg::LEVEL_W-1:0]    blue_level
);
   import jesc_pkg::*;

   localparam int CNT_W      = $clog2(MAX_ITERATIONS + 2);
   localparam int USED_BITS  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << USED_BITS) - 64'd1);
   localparam int MAP_W      = COORD_W + STEP_W;
   localparam int LVL_W      = CNT_W + SCALE_W;
   localparam logic [PROD_W-1:0] LIMIT   = 64'd16 << (2 * FRAC_BITS);
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_ITERATIONS);

   logic [MAP_W-1:0]          map_re_ff, map_im_ff;
   logic [MAP_W-1:0]          map_re_in, map_im_in;
   logic signed [VALUE_W-1:0] re_ff, im_ff;
   logic signed [VALUE_W-1:0] start_re_in, start_im_in;
   logic signed [VALUE_W-1:0] next_re_in, next_im_in;
   logic signed [PROD_W-1:0]  rr_ff, ii_ff, ri_ff;
   logic signed [PROD_W-1:0]  rr_in, ii_in, ri_in;
   logic signed [PROD_W-1:0]  diff;
   logic [PROD_W-1:0]         mag;
   logic [CNT_W-1:0]          count_ff;
   logic [LVL_W-1:0]          red_prod, green_prod, blue_prod;

   // index times step, taken straight from the request port
   assign map_re_in = MAP_W'(column & COORD_MASK) * MAP_W'(cfg.real_step);
   assign map_im_in = MAP_W'(row & COORD_MASK) * MAP_W'(cfg.imag_step);

   // origin plus offset, saturated
   assign start_re_in = sat32(PROD_W'($signed(cfg.real_origin))
                              + $signed({{(PROD_W-MAP_W){1'b0}}, map_re_ff}));
   assign start_im_in = sat32(PROD_W'($signed(cfg.imag_origin))
                              + $signed({{(PROD_W-MAP_W){1'b0}}, map_im_ff}));

   // exact squares and cross product of the current point
   assign rr_in = PROD_W'(re_ff) * PROD_W'(re_ff);
   assign ii_in = PROD_W'(im_ff) * PROD_W'(im_ff);
   assign ri_in = PROD_W'(re_ff) * PROD_W'(im_ff);

   // floor shift back to fixed point, add the seed, saturate
   assign diff       = rr_ff - ii_ff;
   assign next_re_in = sat32((diff >>> FRAC_BITS) + PROD_W'($signed(cfg.seed_real)));
   assign next_im_in = sat32((ri_ff >>> (FRAC_BITS - 1)) + PROD_W'($signed(cfg.seed_imag)));

   // escape test on the squared magnitude, and the iteration limit
   assign mag             = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign status.finished = (count_ff >= MAX_CNT) || (mag > LIMIT);

   // colour levels from the final count
   assign red_prod   = LVL_W'(count_ff) * LVL_W'(cfg.color_scales[3:0]);
   assign green_prod = LVL_W'(count_ff) * LVL_W'(cfg.color_scales[7:4]);
   assign blue_prod  = LVL_W'(count_ff) * LVL_W'(cfg.color_scales[11:8]);

   // datapath registers, loaded on command
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         map_re_ff <= map_re_in;
         map_im_ff <= map_im_in;
      end
      if (cmd.map_add) begin
         re_ff    <= start_re_in;
         im_ff    <= start_im_in;
         count_ff <= '0;
      end
      if (cmd.iter_mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.iter_upd) begin
         re_ff    <= next_re_in;
         im_ff    <= next_im_in;
         count_ff <= CNT_W'(count_ff + 1'b1);
      end
      if (cmd.out_load) begin
         escape_count <= COUNT_W'(count_ff);
         red_level    <= LEVEL_W'(red_prod);
         green_level  <= LEVEL_W'(green_prod);
         blue_level   <= LEVEL_W'(blue_prod);
      end
   end

endmodule

FILE: hw/rtl/jesc_ctrl.sv
// ----------------------------------------------------------------------------
// jesc_ctrl
// Sequencer: accepts a pixel, steps the datapath through mapping and the
// multiply/update phases of each iteration, and owns the result valid.
// ----------------------------------------------------------------------------
module jesc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  jesc_pkg::dp_status_type  status,
   output jesc_pkg::dp_cmd_type     cmd
);
   import jesc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_MUL,
      ST_UPD,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // handshake and command decode
   assign req_ready    = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid    = rsp_valid_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cmd.accept   = req_valid && req_ready;
   assign cmd.map_add  = (state_ff == ST_MAP);
   assign cmd.iter_mul = (state_ff == ST_MUL);
   assign cmd.iter_upd = (state_ff == ST_UPD);
   assign cmd.out_load = (state_ff == ST_FINISH) && out_free;

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept) begin
                  state_ff <= ST_MAP;
               end
            end
            ST_MAP: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               state_ff <= status.finished ? ST_FINISH : ST_MUL;
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Julia-set escape-time engine for one pixel at a time.
// ----------------------------------------------------------------------------
// req_chan takes one item per pixel (column, row). The pixel maps to the
// start point origin + index * step and iterates z = z*z + c in Q6.26 until
// |z|^2 exceeds 16 or the iteration limit is hit. rsp_chan returns one item
// per pixel: the exit count and three colour levels (count times scale).
// Each iteration takes a turn on the shared multiply/update loop:
// products are registered, then shifted, seeded and saturated. A taken
// request passes through the map state, the loop and the finish state,
// where its result waits for a free output; a new request is taken only
// after the previous result is loaded. The default MAX_ITERATIONS is 255.
// Registers on the csr_ port are written one per cycle and must only change
// while no pixel is in flight. Reset restores the register defaults and
// leaves both channels empty. A result waiting on a stalled receiver does
// not stop the next request being taken; only the following result waits.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel #(
   parameter int MAX_ITERATIONS = jesc_pkg::DEF_MAX_ITERATIONS,
   parameter int FRAC_BITS      = jesc_pkg::DEF_FRAC_BITS,
   parameter int COORD_BITS     = jesc_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   jesc_req_if.sink                          req_chan,
   jesc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [jesc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jesc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import jesc_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers
   jesc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   jesc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   jesc_datapath #(
      .MAX_ITERATIONS (MAX_ITERATIONS),
      .FRAC_BITS      (FRAC_BITS),
      .COORD_BITS     (COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .column       (req_chan.column),
      .row          (req_chan.row),
      .escape_count (rsp_chan.escape_count),
      .red_level    (rsp_chan.red_level),
      .green_level  (rsp_chan.green_level),
      .blue_level   (rsp_chan.blue_level)
   );

endmodule

FILE: hw/rtl/jesc_checker.sv
// ----------------------------------------------------------------------------
// jesc_checker
// Port-level checks of the pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module jesc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // one pixel in flight: no request taken in the cycle after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while a pixel is in flight");

   // a new result needs mapping and at least one iteration
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (!$past(req_acc, 1) && !$past(req_acc, 2)
                            && !$past(req_acc, 3)))
      else $error("result appeared too soon after its request");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind julia_escape_time_pixel jesc_checker u_jesc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

FILE: bench/julia_escape_time_pixel_tb.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_tb
// Self-checking bench for the Julia-set escape-time pixel engine. Pixels are
// sent with random gaps and results are taken with random stalls. Each result
// is checked in order against a Q6.26 escape-time predictor that follows
// every register write. Directed items cover the default view, the escape
// limit boundary, start-point and iteration saturation, the iteration limit,
// colour scaling and the unused register index. Random views of connected
// sets and random noise settings follow.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jesc_pkg::*;

   localparam int MAX_ITER     = DEF_MAX_ITERATIONS;
   localparam int FRAC         = DEF_FRAC_BITS;
   localparam int ONE          = 1 << FRAC;
   localparam int DRAIN_CYCLES = 2 * (MAX_ITER + 1) + 8;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 150;

   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [COUNT_W-1:0] escape_count;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
   } pixel_expect_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   jesc_req_if pix_req ();
   jesc_rsp_if pix_rsp ();

   cfg_type          view_cfg;
   pixel_expect_type pending_pixels[$];
   int unsigned      mismatch_count = 0;
   int unsigned      req_gap_max    = 15;
   int unsigned      rsp_stall_max  = 15;

   julia_escape_time_pixel u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pix_req),
      .rsp_chan  (pix_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // clamp to the signed 32-bit range
   function automatic longint clamp_q(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // escape count and colour levels of one pixel under a given setting
   function automatic pixel_expect_type escape_time(input cfg_type c,
                                                    input logic [COORD_W-1:0] column,
                                                    input logic [COORD_W-1:0] row);
      longint           re, im, re_next, seed_re, seed_im;
      longint unsigned  re_sq, im_sq, limit;
      int unsigned      count;
      pixel_expect_type e;
      seed_re = longint'($signed(c.seed_real));
      seed_im = longint'($signed(c.seed_imag));
      re = clamp_q(longint'($signed(c.real_origin)) + longint'(column) * longint'(c.real_step));
      im = clamp_q(longint'($signed(c.imag_origin)) + longint'(row) * longint'(c.imag_step));
      limit = 64'd16 << (2 * FRAC);
      count = 1;
      re_sq = re * re;
      im_sq = im * im;
      // z = z*z + c, products floored back to Q6.26
      while (count <= MAX_ITER && re_sq + im_sq <= limit) begin
         re_next = clamp_q(((re * re - im * im) >>> FRAC) + seed_re);
         im      = clamp_q(((re * im) >>> (FRAC - 1)) + seed_im);
         re      = re_next;
         re_sq   = re * re;
         im_sq   = im * im;
         count++;
      end
      e.column       = column;
      e.row          = row;
      e.escape_count = COUNT_W'(count);
      e.red_level    = LEVEL_W'(count * 32'(c.color_scales[SCALE_W-1:0]));
      e.green_level  = LEVEL_W'(count * 32'(c.color_scales[2*SCALE_W-1:SCALE_W]));
      e.blue_level   = LEVEL_W'(count * 32'(c.color_scales[3*SCALE_W-1:2*SCALE_W]));
      return e;
   endfunction

   function automatic int unsigned pick_idle(input int unsigned max_gap);
      return (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
   endfunction

   // random word, now and then one of the range extremes
   function automatic logic [CSR_DATA_W-1:0] noise_word();
      case ($urandom_range(7, 0))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic void check_field(input string field, input pixel_expect_type want,
                                       input logic [15:0] expected, input logic [15:0] actual);
      if (actual !== expected) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: pixel (%0d,%0d) %s expected %0d got %0d",
                     $time, want.column, want.row, field, expected, actual);
         end
      end
   endfunction

   // one register write, mirrored into the predictor's setting
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_REAL_ORIGIN:  view_cfg.real_origin  = value;
         CSR_IMAG_ORIGIN:  view_cfg.imag_origin  = value;
         CSR_REAL_STEP:    view_cfg.real_step    = value[STEP_W-1:0];
         CSR_IMAG_STEP:    view_cfg.imag_step    = value[STEP_W-1:0];
         CSR_SEED_REAL:    view_cfg.seed_real    = value;
         CSR_SEED_IMAG:    view_cfg.seed_imag    = value;
         CSR_COLOR_SCALES: view_cfg.color_scales = value[SCALES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_view(input logic [CSR_DATA_W-1:0] origin_re,
                           input logic [CSR_DATA_W-1:0] origin_im,
                           input logic [CSR_DATA_W-1:0] step_re,
                           input logic [CSR_DATA_W-1:0] step_im,
                           input logic [CSR_DATA_W-1:0] seed_re,
                           input logic [CSR_DATA_W-1:0] seed_im);
      write_reg(CSR_REAL_ORIGIN, origin_re);
      write_reg(CSR_IMAG_ORIGIN, origin_im);
      write_reg(CSR_REAL_STEP, step_re);
      write_reg(CSR_IMAG_STEP, step_im);
      write_reg(CSR_SEED_REAL, seed_re);
      write_reg(CSR_SEED_IMAG, seed_im);
   endtask

   // one pixel item, predicted once it is taken
   task automatic send_pixel(input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row);
      int unsigned gap;
      gap = pick_idle(req_gap_max);
      if (gap > 0) begin
         pix_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_req.valid  <= 1'b1;
      pix_req.column <= column;
      pix_req.row    <= row;
      @(posedge clock);
      while (!pix_req.ready) @(posedge clock);
      pending_pixels.push_back(escape_time(view_cfg, column, row));
   endtask

   // hold the sender until every pending pixel has come back
   task automatic finish_pixels();
      pix_req.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_view();
      // default window, corners and a point inside the unit disc
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(512, 512);
      send_pixel(1023, 0);
      finish_pixels();
   endtask

   task automatic test_escape_boundary();
      // |z|^2 just under, exactly at and just over 16 on the real axis
      set_view(4 * ONE - 1, 0, 1, 0, 0, 0);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(2, 0);
      finish_pixels();
      // exactly at and just under the limit, negative imaginary axis
      set_view(0, -4 * ONE, 0, 1, 0, 0);
      send_pixel(0, 0);
      send_pixel(0, 1);
      finish_pixels();
   endtask

   task automatic test_start_saturation();
      // start point clamps high on the real side, bottom of range on the imaginary
      set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0);
      send_pixel(1023, 1023);
      send_pixel(1, 0);
      send_pixel(0, 512);
      finish_pixels();
   endtask

   task automatic test_iteration_saturation();
      // real part overflows high after one square
      set_view(3 * ONE, 0, 0, 0, 32'h7FFF_FFFF, 0);
      send_pixel(0, 0);
      finish_pixels();
      // real part underflows with the most negative seed
      set_view(0, 3 * ONE, 0, 0, 32'h8000_0000, 0);
      send_pixel(0, 0);
      finish_pixels();
      // imaginary part overflows high, then low
      set_view(2 * ONE, 2 * ONE, 0, 0, 0, 32'h7FFF_FFFF);
      send_pixel(0, 0);
      finish_pixels();
      set_view(2 * ONE, -2 * ONE, 0, 0, 0, 32'h8000_0000);
      send_pixel(0, 0);
      finish_pixels();
   endtask

   task automatic test_colour_scales();
      // zero is a fixed point: iteration limit reached, full-scale levels
      set_view(0, 0, 0, 0, 0, 0);
      write_reg(CSR_COLOR_SCALES, 32'h0000_0FFF);
      send_pixel(0, 0);
      finish_pixels();
      write_reg(CSR_COLOR_SCALES, 32'h0000_0000);
      send_pixel(1023, 1023);
      finish_pixels();
      // upper bits of the write are dropped
      write_reg(CSR_COLOR_SCALES, 32'hFFFF_F5A3);
      send_pixel(5, 7);
      finish_pixels();
   endtask

   task automatic test_spare_index();
      // classic connected set, negative products floored; spare write is a no-op
      set_view(-(ONE * 3 / 2), -(ONE * 3 / 2), 3 * ONE / 1024, 3 * ONE / 1024,
               -(ONE * 4 / 5), (ONE / 1000) * 156);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      send_pixel(512, 512);
      send_pixel(300, 700);
      finish_pixels();
   endtask

   // window of width 1 to 5 from an origin in [-2.5,-0.5], seed near the set
   task automatic load_julia_view();
      set_view(-int'($urandom_range(5 * ONE / 2, ONE / 2)),
               -int'($urandom_range(5 * ONE / 2, ONE / 2)),
               $urandom_range(5 * ONE / 1024, ONE / 1024),
               $urandom_range(5 * ONE / 1024, ONE / 1024),
               int'($urandom_range(3 * ONE / 2, 0)) - ONE,
               int'($urandom_range(2 * ONE, 0)) - ONE);
      write_reg(CSR_COLOR_SCALES, $urandom());
   endtask

   task automatic load_noise_view();
      for (int i = 0; i <= CSR_COLOR_SCALES; i++) write_reg(CSR_INDEX_W'(i), noise_word());
      write_reg(CSR_SPARE, noise_word());
   endtask

   task automatic test_random_views();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // rotate idling so that each side runs with and without gaps
         case (phase % 4)
            0: begin req_gap_max = 15; rsp_stall_max = 15; end
            1: begin req_gap_max = 0;  rsp_stall_max = 0;  end
            2: begin req_gap_max = 15; rsp_stall_max = 0;  end
            default: begin req_gap_max = 0; rsp_stall_max = 15; end
         endcase
         if (phase % 3 == 2) load_noise_view();
         else load_julia_view();
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // sender waits mid-phase for the pipeline to empty
            if (phase == 5 && n == PHASE_PIXELS / 2) finish_pixels();
            send_pixel(COORD_W'($urandom_range(1023, 0)), COORD_W'($urandom_range(1023, 0)));
         end
         finish_pixels();
      end
   endtask

   // result side: random stalls, in-order check
   initial begin : result_checker
      int unsigned      stall;
      pixel_expect_type want;
      pix_rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_idle(rsp_stall_max);
         if (stall > 0) begin
            pix_rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pix_rsp.ready <= 1'b1;
         @(posedge clock);
         while (!pix_rsp.valid) @(posedge clock);
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: result with no pixel pending, count %0d",
                        $time, pix_rsp.escape_count);
            end
         end else begin
            want = pending_pixels.pop_front();
            check_field("escape_count", want, 16'(want.escape_count),
                        16'(pix_rsp.escape_count));
            check_field("red_level", want, 16'(want.red_level), 16'(pix_rsp.red_level));
            check_field("green_level", want, 16'(want.green_level),
                        16'(pix_rsp.green_level));
            check_field("blue_level", want, 16'(want.blue_level), 16'(pix_rsp.blue_level));
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      pix_req.valid  <= 1'b0;
      pix_req.column <= '0;
      pix_req.row    <= '0;
      view_cfg = '{real_origin:  RST_REAL_ORIGIN,
                   imag_origin:  RST_IMAG_ORIGIN,
                   real_step:    RST_REAL_STEP,
                   imag_step:    RST_IMAG_STEP,
                   seed_real:    RST_SEED_REAL,
                   seed_imag:    RST_SEED_IMAG,
                   color_scales: RST_COLOR_SCALES};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_view();
      test_escape_boundary();
      test_start_saturation();
      test_iteration_saturation();
      test_colour_scales();
      test_spare_index();
      test_random_views();

      finish_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #60_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/jesc_pkg.sv
hw/rtl/jesc_req_if.sv
hw/rtl/jesc_rsp_if.sv
hw/rtl/jesc_csr.sv
hw/rtl/jesc_datapath.sv
hw/rtl/jesc_ctrl.sv
hw/rtl/julia_escape_time_pixel.sv
hw/rtl/jesc_checker.sv
bench/julia_escape_time_pixel_tb.sv
